### design/wfy_pkg.sv
// Package for the windowed Fisher-Yates shuffle block.
// Holds field widths, hash constants, item kinds and the 64-bit fold helper.
// No dependencies.
package wfy_pkg;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEFAULT        = 1024;
   localparam int ELEMENT_BITS_DEFAULT = 8;

   // Fixed field widths
   localparam int KIND_BITS     = 2;
   localparam int INDEX_BITS    = 10;
   localparam int VALUE_BITS    = 8;
   localparam int POS_BITS      = 11;
   localparam int SEED_BITS     = 64;
   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 72;

   // wyhash64 constants
   localparam logic [SEED_BITS-1:0] SEED_STEP  = 64'h60bee2bee120fc15;
   localparam logic [SEED_BITS-1:0] HASH_MUL_A = 64'ha3b195354a39b70d;
   localparam logic [SEED_BITS-1:0] HASH_MUL_B = 64'h1b03738712fad5c9;

   // Item kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_WRITE     = 2'd0,
      KIND_READ      = 2'd1,
      KIND_SHUFFLE   = 2'd2,
      KIND_LOAD_SEED = 2'd3
   } kind_type;

   // Partial products of a 64x64 multiply: [0]=a0*b0 [1]=a0*b1 [2]=a1*b0 [3]=a1*b1
   typedef logic [3:0][63:0] prod_type;

   // Recombine partial products, return high half xor low half
   function automatic logic [63:0] fold_products(input prod_type pp);
      logic [33:0] mid;
      logic [63:0] lo;
      logic [63:0] hi;
      mid = 34'(pp[0][63:32]) + 34'(pp[1][31:0]) + 34'(pp[2][31:0]);
      lo  = {mid[31:0], pp[0][31:0]};
      hi  = pp[3] + 64'(pp[1][63:32]) + 64'(pp[2][63:32]) + 64'(mid[33:32]);
      return hi ^ lo;
   endfunction

endpackage

### design/windowed_fisher_yates_shuffle.sv
// Windowed Fisher-Yates shuffle (uses wfy_pkg): element store, running seed, swap engine.
// Throughput: one transaction at a time; a shuffle spaces its swaps by the multiplier bank
// each draw uses three times, which also orders reads after write-back.
// Reset: seed cleared to zero, control cleared; store contents undefined until written.
module windowed_fisher_yates_shuffle
   import wfy_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // index[9:0], value[17:10], window_low[28:18], window_high[39:29], seed_value[103:40]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // kind[1:0]
   input  logic [KIND_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // read_value[7:0], seed_after[71:8]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // bad_window[0]
   output logic                     rsp_tuser
);

   localparam int ADDR_BITS = $clog2(DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SHUF} state_type;

   // Request fields
   kind_type              req_kind;
   logic [INDEX_BITS-1:0] req_index;
   logic [VALUE_BITS-1:0] req_value;
   logic [POS_BITS-1:0]   req_lo;
   logic [POS_BITS-1:0]   req_hi;
   logic [SEED_BITS-1:0]  req_seed;

   assign req_kind  = kind_type'(req_tuser);
   assign req_index = req_tdata[9:0];
   assign req_value = req_tdata[17:10];
   assign req_lo    = req_tdata[28:18];
   assign req_hi    = req_tdata[39:29];
   assign req_seed  = req_tdata[103:40];

   // Control state
   state_type            state_ff;
   logic [SEED_BITS-1:0] seed_ff;
   logic [POS_BITS-1:0]  lo_ff;
   logic [POS_BITS-1:0]  draws_ff;
   logic [POS_BITS-1:0]  nback_ff;
   logic [7:0]           vld_ff;
   logic [7:0]           vld_in;
   logic                 rd_ok_ff;

   // Hash and swap datapath
   prod_type                pp_ff;
   prod_type                pp_in;
   logic [SEED_BITS-1:0]    mul_x;
   logic [SEED_BITS-1:0]    mul_k;
   logic [SEED_BITS-1:0]    fold_val;
   logic [SEED_BITS-1:0]    f1_ff;
   logic [31:0]             x_ff;
   logic [POS_BITS-1:0]     draw;
   logic [POS_BITS-1:0]     pos_a;
   logic [POS_BITS-1:0]     pos_b;
   logic [ADDR_BITS-1:0]    a_ff;
   logic [ADDR_BITS-1:0]    b_ff;
   logic [ELEMENT_BITS-1:0] hold_ff;

   // Store
   logic [ELEMENT_BITS-1:0] mem [DEPTH];
   logic [ELEMENT_BITS-1:0] rd_a_ff;
   logic [ELEMENT_BITS-1:0] rd_b_ff;
   logic [ADDR_BITS-1:0]    rd_addr_a;
   logic [ADDR_BITS-1:0]    rd_addr_b;
   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ELEMENT_BITS-1:0] wr_data;

   // Result register
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [VALUE_BITS-1:0] rsp_read_ff;
   logic [SEED_BITS-1:0]  rsp_seed_ff;
   logic                  rsp_bad_ff;

   logic                req_fire;
   logic                index_ok;
   logic                win_bad;
   logic [POS_BITS-1:0] win_size;
   logic                issue;
   logic                shuf_done;

   // Handshake and item decode
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign index_ok   = 32'(req_index) < 32'(DEPTH);
   assign win_bad    = (32'(req_hi) > 32'(DEPTH)) || (req_lo > req_hi);
   assign win_size   = req_hi - req_lo;

   // Draw issue: only while vld_ff[1:0] is clear; vld_ff[i] marks a draw in stage i.
   // Stages in order: mult A, fold A, mult B, fold B, scale, read, then the two write-backs
   assign issue     = (state_ff == ST_SHUF) && (draws_ff != '0) && (vld_ff[1:0] == 2'b00);
   assign vld_in    = {vld_ff[6:0], issue};
   assign shuf_done = (draws_ff == '0) && (vld_ff == '0);

   // Shared bank of four 32x32 multipliers
   always_comb begin
      mul_x = seed_ff;
      mul_k = HASH_MUL_A;
      if (vld_ff[2]) begin
         mul_x = f1_ff;
         mul_k = HASH_MUL_B;
      end else if (vld_ff[4]) begin
         mul_x = {32'b0, x_ff};
         mul_k = 64'(nback_ff);
      end
      pp_in[0] = {32'b0, mul_x[31:0]}  * {32'b0, mul_k[31:0]};
      pp_in[1] = {32'b0, mul_x[31:0]}  * {32'b0, mul_k[63:32]};
      pp_in[2] = {32'b0, mul_x[63:32]} * {32'b0, mul_k[31:0]};
      pp_in[3] = {32'b0, mul_x[63:32]} * {32'b0, mul_k[63:32]};
   end

   assign fold_val = fold_products(pp_ff);
   assign draw     = pp_ff[0][32+POS_BITS-1:32];

   // Swap positions: top of the remaining window and the drawn partner
   assign pos_a = POS_BITS'(lo_ff + nback_ff - 1'b1);
   assign pos_b = POS_BITS'(lo_ff + draw);

   assign rd_addr_a = (state_ff == ST_SHUF) ? ADDR_BITS'(pos_a) : ADDR_BITS'(req_index);
   assign rd_addr_b = ADDR_BITS'(pos_b);

   // Write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = a_ff;
      wr_data = rd_b_ff;
      if (vld_ff[6]) begin
         wr_en = 1'b1;
      end else if (vld_ff[7]) begin
         wr_en   = 1'b1;
         wr_addr = b_ff;
         wr_data = hold_ff;
      end else if (req_fire && (req_kind == KIND_WRITE) && index_ok) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_BITS'(req_index);
         wr_data = ELEMENT_BITS'(req_value);
      end
   end

   // Element store, two registered reads, one write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   // Hash and swap payload registers
   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
      if (vld_ff[1]) begin
         f1_ff <= fold_val;
      end
      if (vld_ff[3]) begin
         x_ff <= fold_val[31:0];
      end
      if (vld_ff[5]) begin
         a_ff <= ADDR_BITS'(pos_a);
         b_ff <= ADDR_BITS'(pos_b);
      end
      if (vld_ff[6]) begin
         hold_ff <= rd_a_ff;
      end
   end

   // Result valid: set when a result is loaded, cleared when it is taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (req_fire && ((req_kind == KIND_WRITE) || (req_kind == KIND_LOAD_SEED) ||
                       ((req_kind == KIND_SHUFFLE) && win_bad))) begin
         rsp_tvalid_in = 1'b1;
      end
      if ((state_ff == ST_READ) || ((state_ff == ST_SHUF) && shuf_done)) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seed_ff       <= '0;
         vld_ff        <= '0;
         draws_ff      <= '0;
         nback_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (issue) begin
            seed_ff  <= seed_ff + SEED_STEP;
            draws_ff <= draws_ff - 1'b1;
         end
         if (vld_ff[5]) begin
            nback_ff <= nback_ff - 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  rsp_read_ff <= '0;
                  rsp_seed_ff <= seed_ff;
                  rsp_bad_ff  <= 1'b0;
                  unique case (req_kind)
                     KIND_WRITE: begin
                     end
                     KIND_READ: begin
                        rd_ok_ff <= index_ok;
                        state_ff <= ST_READ;
                     end
                     KIND_SHUFFLE: begin
                        if (win_bad) begin
                           rsp_bad_ff <= 1'b1;
                        end else begin
                           lo_ff    <= req_lo;
                           nback_ff <= win_size;
                           draws_ff <= (win_size > POS_BITS'(1)) ? win_size - 1'b1 : '0;
                           state_ff <= ST_SHUF;
                        end
                     end
                     KIND_LOAD_SEED: begin
                        seed_ff     <= req_seed;
                        rsp_seed_ff <= req_seed;
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_read_ff <= rd_ok_ff ? VALUE_BITS'(rd_a_ff) : '0;
               state_ff    <= ST_IDLE;
            end
            ST_SHUF: begin
               if (shuf_done) begin
                  rsp_seed_ff <= seed_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_seed_ff, rsp_read_ff};
   assign rsp_tuser  = rsp_bad_ff;

   // Shared multiplier bank is never claimed by two draws at once
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({vld_ff[0], vld_ff[2], vld_ff[4]}))
      else $error("multiplier bank claimed by two draws");

   // No draw in flight once the sequencer is back in idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (vld_ff == '0))
      else $error("draw pipeline busy in idle");

   // A rejected window never carries element data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_bad_ff) |-> (rsp_read_ff == '0))
      else $error("bad window result carries read data");

endmodule

### bench/windowed_fisher_yates_shuffle_test.sv
// Self-checking bench for windowed_fisher_yates_shuffle: writes, reads, window shuffles
// and seed loads, predicted in a mirror of the store and seed, with random stream gaps.
// Depends on wfy_pkg and the windowed_fisher_yates_shuffle RTL.
module windowed_fisher_yates_shuffle_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wfy_pkg::*;

   localparam int STORE_DEPTH  = DEPTH_DEFAULT;
   localparam int SPECIES_BITS = ELEMENT_BITS_DEFAULT;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int HOLD_AT      = 50;
   localparam int HOLD_CYCLES  = 250;

   // one request transaction, unpacked
   typedef struct {
      kind_type             kind;
      logic [INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0] value;
      logic [POS_BITS-1:0]   window_low;
      logic [POS_BITS-1:0]   window_high;
      logic [SEED_BITS-1:0]  seed_value;
   } shuffle_item_type;

   // one response transaction
   typedef struct packed {
      logic [SPECIES_BITS-1:0] read_value;
      logic [SEED_BITS-1:0]    seed_after;
      logic                    bad_window;
   } shuffle_result_type;

   // Mirror of the species store and running seed; queues and checks responses
   class shuffle_tracker;
      logic [SPECIES_BITS-1:0] species [STORE_DEPTH];
      logic [SEED_BITS-1:0]    seed;
      shuffle_result_type      awaited[$];
      int                      mismatches;
      int                      checked;
      int                      rejected;
      int                      kind_count[4];

      function new();
         seed       = '0;
         mismatches = 0;
         checked    = 0;
         rejected   = 0;
         foreach (species[i]) species[i] = '0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      // high half of the full 64x64 product folded onto the low half
      function logic [63:0] fold64(logic [63:0] a, logic [63:0] b);
         logic [127:0] prod;
         prod = {64'd0, a} * {64'd0, b};
         return prod[127:64] ^ prod[63:0];
      endfunction

      // step the seed, hash it, scale the low word to [0, count)
      function int draw_partner(int count);
         logic [63:0] h;
         logic [63:0] scaled;
         seed   = seed + SEED_STEP;
         h      = fold64(fold64(seed, HASH_MUL_A), HASH_MUL_B);
         scaled = {32'd0, h[31:0]} * 64'(count);
         return int'(scaled[63:32]);
      endfunction

      // apply an accepted request and queue the response it must produce
      function void note_request(shuffle_item_type item);
         shuffle_result_type      res;
         int                      count;
         int                      top;
         int                      other;
         logic [SPECIES_BITS-1:0] held;
         res = '0;
         kind_count[item.kind]++;
         case (item.kind)
            KIND_WRITE: species[item.index] = item.value;
            KIND_READ: res.read_value = species[item.index];
            KIND_SHUFFLE: begin
               if (item.window_high > STORE_DEPTH || item.window_low > item.window_high) begin
                  res.bad_window = 1'b1;
                  rejected++;
               end else begin
                  // top-down walk, swap top of the remaining part with a drawn partner
                  for (count = item.window_high - item.window_low; count > 1; count--) begin
                     other          = item.window_low + draw_partner(count);
                     top            = item.window_low + count - 1;
                     held           = species[top];
                     species[top]   = species[other];
                     species[other] = held;
                  end
               end
            end
            KIND_LOAD_SEED: seed = item.seed_value;
            default: ;
         endcase
         res.seed_after = seed;
         awaited = {awaited, res};
      endfunction

      // compare one accepted response against the oldest queued one
      function void check_response(logic [RSP_DATA_BITS-1:0] data, logic bad);
         shuffle_result_type got;
         shuffle_result_type want;
         got.read_value = data[SPECIES_BITS-1:0];
         got.seed_after = data[SPECIES_BITS +: SEED_BITS];
         got.bad_window = bad;
         checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d with none pending: read_value %02h seed_after %016h",
                        checked, got.read_value, got.seed_after);
            return;
         end
         want = awaited.pop_front();
         if (got.read_value !== want.read_value || got.seed_after !== want.seed_after ||
             got.bad_window !== want.bad_window) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d mismatch: read_value exp %02h got %02h, bad exp %0b got %0b",
                        checked, want.read_value, got.read_value, want.bad_window,
                        got.bad_window);
               $display("   seed_after exp %016h got %016h", want.seed_after, got.seed_after);
            end
         end
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // index[9:0], value[17:10], window_low[28:18], window_high[39:29], seed_value[103:40]
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   // kind[1:0]
   logic [KIND_BITS-1:0]     req_tuser  = KIND_WRITE;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // read_value[7:0], seed_after[71:8]
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // bad_window[0]
   logic                     rsp_tuser;

   shuffle_tracker tracker = new();

   // stimulus-side bookkeeping: which positions hold a written species code
   bit filled [STORE_DEPTH];
   int filled_list[$];
   int items_sent    = 0;
   int sender_run    = 0;
   bit sender_burst  = 1'b0;
   int cycle_count   = 0;

   windowed_fisher_yates_shuffle DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("windowed_fisher_yates_shuffle_test NOT OK");
         $finish;
      end
   end

   // all fields random; callers override what the kind uses
   function automatic shuffle_item_type random_item(kind_type kind);
      shuffle_item_type item;
      item.kind        = kind;
      item.index       = INDEX_BITS'($urandom);
      item.value       = VALUE_BITS'($urandom);
      item.window_low  = POS_BITS'($urandom);
      item.window_high = POS_BITS'($urandom);
      item.seed_value  = {$urandom, $urandom};
      return item;
   endfunction

   // offer one transaction after a random gap, wait for acceptance
   task automatic send_item(shuffle_item_type item);
      int gap;
      if (sender_run == 0) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         sender_run   = $urandom_range(8, 25);
      end
      sender_run--;
      gap = sender_burst ? 0 : $urandom_range(0, 6);
      if (item.kind == KIND_WRITE && !filled[item.index]) begin
         filled[item.index] = 1'b1;
         filled_list = {filled_list, int'(item.index)};
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.kind;
      req_tdata  <= {item.seed_value, item.window_high, item.window_low, item.value, item.index};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(item);
      items_sent++;
   endtask

   task automatic write_elem(int index, logic [VALUE_BITS-1:0] value);
      shuffle_item_type item;
      item       = random_item(KIND_WRITE);
      item.index = INDEX_BITS'(index);
      item.value = value;
      send_item(item);
   endtask

   task automatic read_elem(int index);
      shuffle_item_type item;
      item       = random_item(KIND_READ);
      item.index = INDEX_BITS'(index);
      send_item(item);
   endtask

   task automatic read_filled();
      read_elem(filled_list[$urandom_range(0, filled_list.size() - 1)]);
   endtask

   task automatic shuffle_window(int lo, int hi);
      shuffle_item_type item;
      item             = random_item(KIND_SHUFFLE);
      item.window_low  = POS_BITS'(lo);
      item.window_high = POS_BITS'(hi);
      send_item(item);
   endtask

   task automatic load_seed(logic [SEED_BITS-1:0] seed);
      shuffle_item_type item;
      item            = random_item(KIND_LOAD_SEED);
      item.seed_value = seed;
      send_item(item);
   endtask

   // fill a run of positions, shuffle windows inside it, read some back
   task automatic run_sequence(int len);
      int base;
      int k;
      int lo;
      int hi;
      base = $urandom_range(0, STORE_DEPTH - len);
      for (k = 0; k < len; k++) write_elem(base + k, VALUE_BITS'($urandom));
      repeat ($urandom_range(1, 3)) begin
         lo = $urandom_range(base, base + len);
         hi = $urandom_range(lo, base + len);
         shuffle_window(lo, hi);
      end
      repeat ($urandom_range(1, 3)) read_filled();
   endtask

   // mostly well-formed sequences, the rest single noise transactions
   task automatic run_random(int quota);
      int pick;
      int hi;
      while (items_sent < quota) begin
         pick = $urandom_range(0, 9);
         case (pick)
            6: begin
               // rejected window: past the store or reversed
               if ($urandom_range(0, 1) == 1)
                  shuffle_window($urandom_range(0, 2047), $urandom_range(STORE_DEPTH + 1, 2047));
               else begin
                  hi = $urandom_range(0, 2046);
                  shuffle_window($urandom_range(hi + 1, 2047), hi);
               end
            end
            7: load_seed({$urandom, $urandom});
            8: read_filled();
            9: write_elem($urandom_range(0, STORE_DEPTH - 1), VALUE_BITS'($urandom));
            default: run_sequence($urandom_range(2, 12));
         endcase
      end
   endtask

   // stop offering until every queued response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.awaited.size() != 0);
   endtask

   // response side: random ready gaps, one long hold to back up the input
   initial begin : response_side
      int gap;
      int run;
      bit burst;
      int seen;
      run  = 0;
      seen = 0;
      wait (!reset);
      forever begin
         if (run == 0) begin
            burst = ($urandom_range(0, 3) == 0);
            run   = $urandom_range(8, 25);
         end
         run--;
         gap = burst ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_response(rsp_tdata, rsp_tuser);
         seen++;
         if (seen == HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   // request side
   initial begin : request_side
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: both ends of the store, field extremes, short and rejected windows
      write_elem(0, 8'h00);
      write_elem(1, 8'hFF);
      write_elem(2, 8'h55);
      write_elem(3, 8'hAA);
      write_elem(4, 8'h01);
      write_elem(5, 8'h80);
      for (k = STORE_DEPTH - 6; k < STORE_DEPTH; k++) write_elem(k, VALUE_BITS'($urandom));
      load_seed('1);
      read_elem(0);
      read_elem(STORE_DEPTH - 1);
      shuffle_window(0, 6);
      shuffle_window(STORE_DEPTH - 6, STORE_DEPTH);
      shuffle_window(STORE_DEPTH, STORE_DEPTH);  // empty window at the very end
      shuffle_window(3, 4);                      // single element
      shuffle_window(0, STORE_DEPTH + 1);        // runs past the store
      shuffle_window(6, 2);                      // reversed
      shuffle_window(2047, 2047);
      load_seed('0);
      shuffle_window(0, 6);
      read_elem(5);
      read_elem(STORE_DEPTH - 6);

      run_random(70);
      wait_drained();
      run_sequence(32);
      run_random(135);

      wait_drained();
      repeat (40) @(posedge clock);
      $display("%0d transactions: %0d writes, %0d reads, %0d seed loads, %0d shuffles",
               items_sent, tracker.kind_count[KIND_WRITE], tracker.kind_count[KIND_READ],
               tracker.kind_count[KIND_LOAD_SEED], tracker.kind_count[KIND_SHUFFLE]);
      $display("%0d rejected windows, %0d responses checked, %0d mismatches, %0d cycles",
               tracker.rejected, tracker.checked, tracker.mismatches, cycle_count);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("windowed_fisher_yates_shuffle_test OK");
      end else begin
         $display("windowed_fisher_yates_shuffle_test NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
design/wfy_pkg.sv
design/windowed_fisher_yates_shuffle.sv
bench/windowed_fisher_yates_shuffle_test.sv
